// ===== rtl/lsm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsm_pkg
// Shared types and constants for the LRU slot mapper.
// ----------------------------------------------------------------------------
package lsm_pkg;

    // field widths fixed by the interface
    localparam int ID_W   = 32;
    localparam int SLOT_W = 4;
    localparam int CAP_W  = 5;

    // build defaults
    localparam int SLOTS_DEFAULT = 16;
    localparam int CAP_RESET     = 16;

    // request kinds
    typedef enum logic {
        REQ_LOOKUP = 1'b0,
        REQ_INSERT = 1'b1
    } req_type_t;

endpackage

// ===== rtl/lsm_search.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsm_search
// Parallel compare of a key against all live slots, plus location of the
// least recent live slot and the id it holds.
// ----------------------------------------------------------------------------
module lsm_search #(
    parameter int SLOTS = lsm_pkg::SLOTS_DEFAULT
) (
    input  logic [lsm_pkg::ID_W-1:0]       key,
    input  logic [lsm_pkg::ID_W-1:0]       ids      [SLOTS],
    input  logic [$clog2(SLOTS)-1:0]       rec      [SLOTS],
    input  logic [$clog2(SLOTS+1)-1:0]     fill,
    output logic                           hit,
    output logic [$clog2(SLOTS)-1:0]       hit_idx,
    output logic [$clog2(SLOTS)-1:0]       hit_rank,
    output logic [$clog2(SLOTS)-1:0]       lru_idx,
    output logic [lsm_pkg::ID_W-1:0]       lru_id
);

    localparam int IW = $clog2(SLOTS);
    localparam int CW = $clog2(SLOTS + 1);

    logic [CW-1:0] oldest_full;
    logic [IW-1:0] oldest_rank;
    logic [SLOTS-1:0] live;
    logic [SLOTS-1:0] match;
    logic [SLOTS-1:0] oldest;

    // rank held by the least recent live entry
    assign oldest_full = fill - CW'(1);
    assign oldest_rank = oldest_full[IW-1:0];

    // per-slot compare; live ids are unique so at most one match
    always_comb
    begin
        for (int i = 0; i < SLOTS; i++)
        begin
            live[i]   = (CW'(i) < fill);
            match[i]  = live[i] && (ids[i] == key);
            oldest[i] = live[i] && (rec[i] == oldest_rank);
        end
    end

    // one-hot to index and data by or-reduction
    always_comb
    begin
        hit_idx  = '0;
        hit_rank = '0;
        lru_idx  = '0;
        lru_id   = '0;
        for (int i = 0; i < SLOTS; i++)
        begin
            if (match[i])
            begin
                hit_idx  = hit_idx | IW'(i);
                hit_rank = hit_rank | rec[i];
            end
            if (oldest[i])
            begin
                lru_idx = lru_idx | IW'(i);
                lru_id  = lru_id | ids[i];
            end
        end
    end

    assign hit = |match;

endmodule

// ===== rtl/lru_slot_mapper_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_slot_mapper_core
// Fully associative LRU map from a block id to a buffer slot position.
// ----------------------------------------------------------------------------
// Usage:
//   A request (req_type, block_id) is taken at a clock edge with start high
//   and busy low; busy never rises, so one request can enter every cycle.
//   The request is registered, then the compare over all live slots, the
//   rank update and the store write happen in the following cycle, which
//   also loads the result register. done is high for one cycle with hit,
//   slot, evicted and evicted_block. Throughput is one request per cycle,
//   set by the combinational compare and rank update across all slots.
//   The capacity register is written through cfg_valid/cfg_ready (always
//   ready); the user must write it only while no request is in flight, and
//   the block itself does not enforce this. Each write clamps the value to
//   1..SLOTS and empties the map.
//   Reset empties the map and sets capacity to its reset value; no clearing
//   pass runs, the block takes requests right after reset.
//   done is a strobe; the receiver cannot stall it.
// ----------------------------------------------------------------------------
module lru_slot_mapper_core #(
    parameter int SLOTS = lsm_pkg::SLOTS_DEFAULT
) (
    input  logic                         clk,
    input  logic                         rst_n,
    // request channel
    input  logic                         start,
    output logic                         busy,
    input  logic                         req_type,
    input  logic [lsm_pkg::ID_W-1:0]     block_id,
    // capacity write channel
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [lsm_pkg::CAP_W-1:0]    cfg_data,
    // result channel
    output logic                         done,
    output logic                         hit,
    output logic [lsm_pkg::SLOT_W-1:0]   slot,
    output logic                         evicted,
    output logic [lsm_pkg::ID_W-1:0]     evicted_block
);

    localparam int IW = $clog2(SLOTS);
    localparam int CW = $clog2(SLOTS + 1);
    localparam int XW = (CW > lsm_pkg::CAP_W) ? CW : lsm_pkg::CAP_W;
    localparam logic [CW-1:0] CAP_INIT =
        CW'((lsm_pkg::CAP_RESET > SLOTS) ? SLOTS : lsm_pkg::CAP_RESET);

    // request register
    logic                     req_valid_reg;
    lsm_pkg::req_type_t       req_kind_reg;
    logic [lsm_pkg::ID_W-1:0] req_id_reg;

    // map state
    logic [lsm_pkg::ID_W-1:0] id_reg   [SLOTS];
    logic [lsm_pkg::ID_W-1:0] id_next  [SLOTS];
    logic [IW-1:0]            rec_reg  [SLOTS];
    logic [IW-1:0]            rec_next [SLOTS];
    logic [CW-1:0]            fill_reg;
    logic [CW-1:0]            fill_next;
    logic [CW-1:0]            cap_reg;
    logic [CW-1:0]            cap_next;

    // result register
    logic                     done_reg;
    logic                     done_next;
    logic                     hit_reg;
    logic                     hit_next;
    logic [lsm_pkg::SLOT_W-1:0] slot_reg;
    logic [lsm_pkg::SLOT_W-1:0] slot_next;
    logic                     evicted_reg;
    logic                     evicted_next;
    logic [lsm_pkg::ID_W-1:0] evblk_reg;
    logic [lsm_pkg::ID_W-1:0] evblk_next;

    // search results
    logic                     s_hit;
    logic [IW-1:0]            s_hit_idx;
    logic [IW-1:0]            s_hit_rank;
    logic [IW-1:0]            s_lru_idx;
    logic [lsm_pkg::ID_W-1:0] s_lru_id;

    // update control
    logic                     do_touch;
    logic [IW-1:0]            touch_idx;
    logic [IW-1:0]            touch_rank;
    logic [CW-1:0]            oldest_full;
    logic                     has_room;
    logic [IW-1:0]            fill_idx;
    logic                     cfg_write;
    logic [XW-1:0]            cfg_wide;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    assign oldest_full = fill_reg - CW'(1);
    assign has_room    = (fill_reg < cap_reg);
    assign fill_idx    = fill_reg[IW-1:0];

    // parallel compare over the live slots
    lsm_search #(
        .SLOTS (SLOTS)
    ) u_search (
        .key      (req_id_reg),
        .ids      (id_reg),
        .rec      (rec_reg),
        .fill     (fill_reg),
        .hit      (s_hit),
        .hit_idx  (s_hit_idx),
        .hit_rank (s_hit_rank),
        .lru_idx  (s_lru_idx),
        .lru_id   (s_lru_id)
    );

    // capacity clamp to 1..SLOTS
    assign cfg_wide = XW'(cfg_data);

    always_comb
    begin
        priority if (cfg_wide == '0)
            cap_next = CW'(1);
        else if (cfg_wide > XW'(SLOTS))
            cap_next = CW'(SLOTS);
        else
            cap_next = cfg_wide[CW-1:0];
    end

    // request decode: which slot moves to the front, and the result
    always_comb
    begin
        do_touch     = 1'b0;
        touch_idx    = s_hit_idx;
        touch_rank   = s_hit_rank;
        done_next    = req_valid_reg;
        hit_next     = s_hit;
        slot_next    = '0;
        evicted_next = 1'b0;
        evblk_next   = '0;
        if (req_valid_reg)
        begin
            priority if (s_hit)
            begin
                do_touch  = 1'b1;
                slot_next = lsm_pkg::SLOT_W'(s_hit_idx);
            end
            else if (req_kind_reg == lsm_pkg::REQ_INSERT)
            begin
                if (has_room)
                begin
                    slot_next = lsm_pkg::SLOT_W'(fill_idx);
                end
                else
                begin
                    do_touch     = 1'b1;
                    touch_idx    = s_lru_idx;
                    touch_rank   = oldest_full[IW-1:0];
                    slot_next    = lsm_pkg::SLOT_W'(s_lru_idx);
                    evicted_next = 1'b1;
                    evblk_next   = s_lru_id;
                end
            end
            else
            begin
                slot_next = '0;
            end
        end
    end

    // next state of the store, ranks and fill count
    always_comb
    begin
        fill_next = fill_reg;
        for (int i = 0; i < SLOTS; i++)
        begin
            id_next[i]  = id_reg[i];
            rec_next[i] = rec_reg[i];
        end
        if (cfg_write)
        begin
            fill_next = '0;
            for (int i = 0; i < SLOTS; i++)
            begin
                rec_next[i] = '0;
            end
        end
        else if (req_valid_reg)
        begin
            if (do_touch)
            begin
                // entries more recent than the touched one age by one
                for (int i = 0; i < SLOTS; i++)
                begin
                    if ((CW'(i) < fill_reg) && (rec_reg[i] < touch_rank))
                        rec_next[i] = rec_reg[i] + IW'(1);
                end
                rec_next[touch_idx] = '0;
                if (!s_hit)
                    id_next[touch_idx] = req_id_reg;
            end
            else if (!s_hit && (req_kind_reg == lsm_pkg::REQ_INSERT) && has_room)
            begin
                // fill the next free slot, every live entry ages
                for (int i = 0; i < SLOTS; i++)
                begin
                    if (CW'(i) < fill_reg)
                        rec_next[i] = rec_reg[i] + IW'(1);
                end
                rec_next[fill_idx] = '0;
                id_next[fill_idx]  = req_id_reg;
                fill_next          = fill_reg + CW'(1);
            end
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg <= 1'b0;
            done_reg      <= 1'b0;
            fill_reg      <= '0;
            cap_reg       <= CAP_INIT;
            for (int i = 0; i < SLOTS; i++)
            begin
                rec_reg[i] <= '0;
            end
        end
        else
        begin
            req_valid_reg <= start && !busy;
            done_reg      <= done_next;
            fill_reg      <= fill_next;
            if (cfg_write)
                cap_reg <= cap_next;
            for (int i = 0; i < SLOTS; i++)
            begin
                rec_reg[i] <= rec_next[i];
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            req_kind_reg <= lsm_pkg::req_type_t'(req_type);
            req_id_reg   <= block_id;
        end
        for (int i = 0; i < SLOTS; i++)
        begin
            id_reg[i] <= id_next[i];
        end
        hit_reg     <= hit_next;
        slot_reg    <= slot_next;
        evicted_reg <= evicted_next;
        evblk_reg   <= evblk_next;
    end

    assign done          = done_reg;
    assign hit           = hit_reg;
    assign slot          = slot_reg;
    assign evicted       = evicted_reg;
    assign evicted_block = evblk_reg;

endmodule
